// ===== rtl/rcfd_pkg.sv =====
// ----------------------------------------------------------------------------
// rcfd_pkg
// Shared types, constants and the CRC-8 fold for the RC channel frame decoder.
// ----------------------------------------------------------------------------
package rcfd_pkg;

  localparam int PayloadBytes = 22;
  localparam int Channels     = 16;
  localparam int ChanBits     = 11;
  localparam int PayloadBits  = PayloadBytes * 8;
  localparam int CountBits    = 9;
  localparam int FifoDepth    = 2;
  localparam int FifoPtrBits  = $clog2(FifoDepth);
  localparam int FifoCntBits  = $clog2(FifoDepth + 1);
  localparam int IdxBits      = $clog2(Channels);
  localparam int CfgIdxBits   = 2;
  localparam int MinFrameLen  = 5;
  localparam int HdrBytes     = 3;

  localparam logic [CountBits-1:0] CountMax = '1;

  // status codes
  localparam logic [2:0] StOk         = 3'd0;
  localparam logic [2:0] StTooShort   = 3'd1;
  localparam logic [2:0] StBadSync    = 3'd2;
  localparam logic [2:0] StLenMismat  = 3'd3;
  localparam logic [2:0] StWrongType  = 3'd4;
  localparam logic [2:0] StWrongPlen  = 3'd5;
  localparam logic [2:0] StCrcMismat  = 3'd6;

  // configuration register indexes
  localparam logic [CfgIdxBits-1:0] RegSyncValue    = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegChannelsType = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegCrcPoly      = 2'd2;

  localparam logic [7:0] SyncReset  = 8'd200;
  localparam logic [7:0] TypeReset  = 8'd22;
  localparam logic [7:0] PolyReset  = 8'd213;

  typedef struct packed {
    logic [7:0] sync_value;
    logic [7:0] channels_type;
    logic [7:0] crc_polynomial;
  } cfg_t;

  // one frame verdict handed from front to back
  typedef struct packed {
    logic [2:0]             status;
    logic [PayloadBits-1:0] payload;
  } job_t;

  function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b,
                                          input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/rcfd_front.sv =====
// ----------------------------------------------------------------------------
// rcfd_front
// Byte intake: counts, captures header and payload, folds CRC, judges frame.
// ----------------------------------------------------------------------------
module rcfd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rcfd_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    rx_byte_i,
  input  logic          end_of_frame_i,
  input  logic          full_i,
  output logic          push_o,
  output rcfd_pkg::job_t job_o
);
  import rcfd_pkg::*;

  logic [CountBits-1:0] count_q, count_d;
  logic [7:0]           crc_q, crc_d;
  logic [7:0]           first_q, first_d;
  logic [7:0]           len_q, len_d;
  logic [7:0]           type_q, type_d;
  logic [7:0]           store_q [PayloadBytes];

  logic                 accept;
  logic [CountBits:0]   total_len;
  logic [CountBits:0]   len_plus2;
  logic [CountBits:0]   pay_off;
  logic [2:0]           status;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && end_of_frame_i;

  assign total_len = {1'b0, count_q} + (CountBits+1)'(1);
  assign len_plus2 = (CountBits+1)'(len_q) + (CountBits+1)'(2);
  assign pay_off   = {1'b0, count_q} - (CountBits+1)'(HdrBytes);

  always_comb begin
    if (total_len < (CountBits+1)'(MinFrameLen)) begin
      status = StTooShort;
    end else if (first_q != cfg_i.sync_value) begin
      status = StBadSync;
    end else if (len_plus2 != total_len) begin
      status = StLenMismat;
    end else if (type_q != cfg_i.channels_type) begin
      status = StWrongType;
    end else if (len_q != 8'(PayloadBytes + 2)) begin
      status = StWrongPlen;
    end else if (rx_byte_i != crc_q) begin
      status = StCrcMismat;
    end else begin
      status = StOk;
    end
  end

  always_comb begin
    job_o.status = status;
    for (int i = 0; i < PayloadBytes; i++) begin
      job_o.payload[i*8 +: 8] = store_q[i];
    end
  end

  always_comb begin
    count_d = count_q;
    crc_d   = crc_q;
    first_d = first_q;
    len_d   = len_q;
    type_d  = type_q;
    if (accept) begin
      if (end_of_frame_i) begin
        count_d = '0;
        crc_d   = '0;
        first_d = '0;
        len_d   = '0;
        type_d  = '0;
      end else begin
        if (count_q == CountBits'(0)) first_d = rx_byte_i;
        if (count_q == CountBits'(1)) len_d   = rx_byte_i;
        if (count_q == CountBits'(2)) type_d  = rx_byte_i;
        if (count_q >= CountBits'(2)) crc_d = crc_fold(crc_q, rx_byte_i, cfg_i.crc_polynomial);
        if (count_q != CountMax) count_d = count_q + CountBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      crc_q   <= '0;
      first_q <= '0;
      len_q   <= '0;
      type_q  <= '0;
    end else begin
      count_q <= count_d;
      crc_q   <= crc_d;
      first_q <= first_d;
      len_q   <= len_d;
      type_q  <= type_d;
    end
  end

  // payload bytes land at count - 3 while inside the payload window
  always_ff @(posedge clk_i) begin
    if (accept && !end_of_frame_i && count_q >= CountBits'(HdrBytes)
        && pay_off < (CountBits+1)'(PayloadBytes)) begin
      store_q[pay_off[$clog2(PayloadBytes)-1:0]] <= rx_byte_i;
    end
  end

endmodule

// ===== rtl/rcfd_fifo.sv =====
// ----------------------------------------------------------------------------
// rcfd_fifo
// Short queue of frame verdicts between the intake and the emitter.
// ----------------------------------------------------------------------------
module rcfd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rcfd_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output rcfd_pkg::job_t job_o
);
  import rcfd_pkg::*;

  job_t                   mem_q [FifoDepth];
  logic [FifoPtrBits-1:0] wr_q, rd_q;
  logic [FifoCntBits-1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == FifoCntBits'(FifoDepth);
  assign valid_o = cnt_q != '0;
  assign job_o   = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + FifoCntBits'(1);
    if (!push_i && pop_i) cnt_d = cnt_q - FifoCntBits'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_q <= wr_q + FifoPtrBits'(1);
      if (pop_i)  rd_q <= rd_q + FifoPtrBits'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

endmodule

// ===== rtl/rcfd_back.sv =====
// ----------------------------------------------------------------------------
// rcfd_back
// Emitter: turns a verdict into one status beat or sixteen channel beats.
// ----------------------------------------------------------------------------
module rcfd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  rcfd_pkg::job_t job_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [2:0]     frame_status_o,
  output logic [3:0]     channel_index_o,
  output logic [10:0]    channel_value_o,
  output logic           last_result_o
);
  import rcfd_pkg::*;

  logic                   active_q, active_d;
  logic [2:0]             status_q;
  logic [PayloadBits-1:0] pay_q;
  logic [IdxBits-1:0]     idx_q;

  logic                   out_valid_q;
  logic [2:0]             status_out_q;
  logic [3:0]             index_out_q;
  logic [10:0]            value_out_q;
  logic                   last_out_q;

  logic emit, emit_last, is_ok;

  assign is_ok     = status_q == StOk;
  assign emit      = active_q && (!out_valid_q || out_ready_i);
  assign emit_last = emit && (!is_ok || idx_q == IdxBits'(Channels - 1));
  assign pop_o     = job_valid_i && (!active_q || emit_last);

  always_comb begin
    active_d = active_q;
    if (pop_o) begin
      active_d = 1'b1;
    end else if (emit_last) begin
      active_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q <= active_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload shifts down one channel per beat; channel n is always at the bottom
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q <= job_i.status;
      pay_q    <= job_i.payload;
      idx_q    <= '0;
    end else if (emit) begin
      pay_q <= pay_q >> ChanBits;
      idx_q <= idx_q + IdxBits'(1);
    end
    if (emit) begin
      status_out_q <= status_q;
      index_out_q  <= is_ok ? 4'(idx_q) : 4'd0;
      value_out_q  <= is_ok ? pay_q[ChanBits-1:0] : 11'd0;
      last_out_q   <= emit_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign frame_status_o  = status_out_q;
  assign channel_index_o = index_out_q;
  assign channel_value_o = value_out_q;
  assign last_result_o   = last_out_q;

endmodule

// ===== rtl/rc_channel_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// rc_channel_frame_decoder
// RC channels frame decoder: byte intake, verdict queue, channel emitter.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle; the CRC-8 fold of a byte completes in the
// cycle it is accepted. On the byte flagged end_of_frame the frame is judged
// and the verdict, with a copy of the 22 payload bytes, goes into a two-entry
// queue, so the next frame can stream in at once. The emitter drains the
// queue at one result beat per cycle while out_ready is high: a good frame
// gives 16 beats (channels 0..15, last_result on channel 15), a bad frame one
// status beat. Intake stalls only while the queue is full, i.e. when frame
// ends arrive faster than the emitter delivers their beats. Config writes
// take effect the next cycle and are expected only while the block is idle.
// ----------------------------------------------------------------------------
module rc_channel_frame_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        end_of_frame_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  frame_status_o,
  output logic [3:0]  channel_index_o,
  output logic [10:0] channel_value_o,
  output logic        last_result_o
);
  import rcfd_pkg::*;

  cfg_t cfg_q;
  job_t push_job, head_job;
  logic push, full, head_valid, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_value     <= SyncReset;
      cfg_q.channels_type  <= TypeReset;
      cfg_q.crc_polynomial <= PolyReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegSyncValue:    cfg_q.sync_value     <= cfg_wdata_i;
        RegChannelsType: cfg_q.channels_type  <= cfg_wdata_i;
        RegCrcPoly:      cfg_q.crc_polynomial <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  rcfd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .end_of_frame_i (end_of_frame_i),
    .full_i         (full),
    .push_o         (push),
    .job_o          (push_job)
  );

  rcfd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .job_o   (head_job)
  );

  rcfd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (head_valid),
    .job_i           (head_job),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .frame_status_o  (frame_status_o),
    .channel_index_o (channel_index_o),
    .channel_value_o (channel_value_o),
    .last_result_o   (last_result_o)
  );

endmodule
